// ===== rtl/core/mips_subset_control_decoder_assert.svh =====
// Assertion macros used by the control decoder top-level RTL.
`ifndef MIPS_SUBSET_CONTROL_DECODER_ASSERT_SVH
`define MIPS_SUBSET_CONTROL_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MSCD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("control decoder: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MSCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("control decoder: next-cycle check failed");

`endif

// ===== rtl/core/mscd_pkg.sv =====
// Types and encoding constants for the MIPS subset control decoder.
`default_nettype none

package mscd_pkg;

  // Instruction field positions.
  localparam int unsigned OPCODE_MSB = 31;
  localparam int unsigned OPCODE_LSB = 26;
  localparam int unsigned FUNCT_MSB  = 5;

  // Primary opcodes.
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type function codes.
  localparam logic [5:0] FN_NOP  = 6'd0;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;

  // ALU second-operand source.
  localparam logic [1:0] SRC_REG  = 2'd0;
  localparam logic [1:0] SRC_SIMM = 2'd1;
  localparam logic [1:0] SRC_ZIMM = 2'd2;

  // ALU operation.
  localparam logic [2:0] ALU_AND = 3'd0;
  localparam logic [2:0] ALU_OR  = 3'd1;
  localparam logic [2:0] ALU_ADD = 3'd2;
  localparam logic [2:0] ALU_SLT = 3'd3;
  localparam logic [2:0] ALU_XOR = 3'd4;
  localparam logic [2:0] ALU_NOP = 3'd5;

  // Special marker.
  localparam logic [1:0] SPC_NONE   = 2'd0;
  localparam logic [1:0] SPC_NORBNE = 2'd1;
  localparam logic [1:0] SPC_LUI    = 2'd2;

  // Operand-clear code for the pipeline register.
  localparam logic [1:0] CLR_KEEP = 2'd0;
  localparam logic [1:0] CLR_REGS = 2'd1;
  localparam logic [1:0] CLR_NOP  = 2'd2;
  localparam logic [1:0] CLR_ALL  = 2'd3;

  // Input transaction.
  typedef struct packed {
    logic [31:0] instruction;
    logic        stall_req;
  } insn_t;

  // Result transaction: the ID/EX control word.
  typedef struct packed {
    logic [1:0] alu_src;
    logic [2:0] alu_op;
    logic       b_negate;
    logic       mem_read;
    logic       mem_write;
    logic       mem_to_reg;
    logic       reg_dst;
    logic       reg_write;
    logic [1:0] special;
    logic [1:0] operand_clear;
    logic       valid_res;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/mscd_decode.sv =====
// Combinational main control decode of one instruction word.
`default_nettype none

module mscd_decode (
  input  mscd_pkg::insn_t insn,
  output mscd_pkg::ctrl_t ctrl
);
  import mscd_pkg::*;

  logic [5:0] opcode;
  logic [5:0] funct;

  assign opcode = insn.instruction[OPCODE_MSB:OPCODE_LSB];
  assign funct  = insn.instruction[FUNCT_MSB:0];

  // A stall outranks decoding; unknown encodings leave everything at zero.
  always_comb begin
    ctrl = '0;
    if (insn.stall_req) begin
      ctrl.operand_clear = CLR_ALL;
      ctrl.valid_res     = 1'b1;
    end else if (opcode == OP_RTYPE) begin
      ctrl.valid_res = 1'b1;
      ctrl.reg_dst   = 1'b1;
      ctrl.reg_write = 1'b1;
      case (funct) inside
        FN_ADD, FN_ADDU: begin
          ctrl.alu_op = ALU_ADD;
        end
        FN_SUB, FN_SUBU: begin
          ctrl.alu_op   = ALU_ADD;
          ctrl.b_negate = 1'b1;
        end
        FN_AND: begin
          ctrl.alu_op = ALU_AND;
        end
        FN_OR: begin
          ctrl.alu_op = ALU_OR;
        end
        FN_XOR: begin
          ctrl.alu_op = ALU_XOR;
        end
        FN_NOR: begin
          ctrl.alu_op  = ALU_OR;
          ctrl.special = SPC_NORBNE;
        end
        FN_SLT: begin
          ctrl.alu_op   = ALU_SLT;
          ctrl.b_negate = 1'b1;
        end
        FN_NOP: begin
          ctrl.alu_op        = ALU_NOP;
          ctrl.operand_clear = CLR_NOP;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end else begin
      ctrl.valid_res = 1'b1;
      case (opcode) inside
        OP_ADDI, OP_ADDIU: begin
          ctrl.alu_src   = SRC_SIMM;
          ctrl.alu_op    = ALU_ADD;
          ctrl.reg_write = 1'b1;
        end
        OP_SLTI: begin
          ctrl.alu_src   = SRC_SIMM;
          ctrl.alu_op    = ALU_SLT;
          ctrl.b_negate  = 1'b1;
          ctrl.reg_write = 1'b1;
        end
        OP_LW: begin
          ctrl.alu_src    = SRC_SIMM;
          ctrl.alu_op     = ALU_ADD;
          ctrl.mem_read   = 1'b1;
          ctrl.mem_to_reg = 1'b1;
          ctrl.reg_write  = 1'b1;
        end
        OP_SW: begin
          ctrl.alu_src   = SRC_SIMM;
          ctrl.alu_op    = ALU_ADD;
          ctrl.mem_write = 1'b1;
        end
        OP_BEQ, OP_J: begin
          ctrl.operand_clear = CLR_REGS;
        end
        OP_BNE: begin
          ctrl.special       = SPC_NORBNE;
          ctrl.operand_clear = CLR_REGS;
        end
        OP_ANDI: begin
          ctrl.alu_src   = SRC_ZIMM;
          ctrl.alu_op    = ALU_AND;
          ctrl.reg_write = 1'b1;
        end
        OP_ORI: begin
          ctrl.alu_src   = SRC_ZIMM;
          ctrl.alu_op    = ALU_OR;
          ctrl.reg_write = 1'b1;
        end
        OP_LUI: begin
          ctrl.alu_src   = SRC_ZIMM;
          ctrl.alu_op    = ALU_XOR;
          ctrl.reg_write = 1'b1;
          ctrl.special   = SPC_LUI;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mips_subset_control_decoder.sv =====
// Path: a transaction accepted into the input register is decoded combinationally and
// registered into ctrl once the output side is free, where it can then be taken.
// Throughput: one instruction per cycle while ctrl_ready stays high, set by the input
// register feeding the decode logic and the control-word register behind it.
// Reset: rst (synchronous) empties both registers; payload is not cleared.
`default_nettype none
`include "mips_subset_control_decoder_assert.svh"

module mips_subset_control_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            insn_valid,
  output logic            insn_ready,
  input  mscd_pkg::insn_t insn,
  output logic            ctrl_valid,
  input  logic            ctrl_ready,
  output mscd_pkg::ctrl_t ctrl
);
  import mscd_pkg::*;

  logic  s1_valid;
  insn_t s1_insn;
  ctrl_t decoded;
  logic  out_free;
  logic  out_bubble;
  logic  bubble_clean;
  logic  unknown_clean;
  logic  load_wb;

  // Each stage moves on when the stage after it is empty or being drained.
  assign out_free   = !ctrl_valid || ctrl_ready;
  assign insn_ready = !s1_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (insn_ready) begin
      s1_valid <= insn_valid;
    end
    if (insn_valid && insn_ready) begin
      s1_insn <= insn;
    end
  end

  mscd_decode u_decode (
    .insn (s1_insn),
    .ctrl (decoded)
  );

  // Control-word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_valid <= 1'b0;
    end else if (out_free) begin
      ctrl_valid <= s1_valid;
    end
    if (s1_valid && out_free) begin
      ctrl <= decoded;
    end
  end

  // Shorthand terms for the control-word checks below.
  assign out_bubble    = ctrl.operand_clear == CLR_ALL;
  assign bubble_clean  = ctrl.valid_res && !ctrl.reg_write && !ctrl.mem_write &&
                         ctrl.alu_op == ALU_AND;
  assign unknown_clean = ctrl.operand_clear == CLR_KEEP && !ctrl.reg_write &&
                         !ctrl.mem_write;
  assign load_wb       = ctrl.mem_to_reg && ctrl.reg_write && !ctrl.mem_write;

  // A held instruction must not change while the output side is blocked.
  `MSCD_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !out_free, s1_valid && $stable(s1_insn))
  // A bubble is marked valid, writes nothing and leaves the ALU operation at zero.
  `MSCD_ASSERT_IMPLIES(a_bubble_clean, clk, rst, ctrl_valid && out_bubble, bubble_clean)
  // An unknown encoding keeps operands and writes nothing.
  `MSCD_ASSERT_IMPLIES(a_unknown_clean, clk, rst, ctrl_valid && !ctrl.valid_res, unknown_clean)
  // A load always writes back from memory.
  `MSCD_ASSERT_IMPLIES(a_load_wb, clk, rst, ctrl_valid && ctrl.mem_read, load_wb)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the MIPS subset control decoder with random flow control.
`timescale 1ns / 100ps

module tb;
  import mscd_pkg::*;

  localparam int RANDOM_ITEMS    = 1400;
  localparam int BURST_ITEMS     = 150;
  localparam int HOLD_ITEMS      = 150;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int KNOWN_ENCODINGS = 21;
  localparam int RTYPE_ENCODINGS = 10;

  logic  clk;
  logic  rst;
  logic  insn_valid;
  logic  insn_ready;
  insn_t insn;
  logic  ctrl_valid;
  logic  ctrl_ready;
  ctrl_t ctrl;

  // Control words predicted for accepted instructions, oldest first.
  ctrl_t pending_ctrl[$];

  bit no_idle         = 1'b0;
  int hold_off_cycles = 0;
  int cycle_count     = 0;
  int mismatch_count  = 0;
  int insns_sent      = 0;
  int stalls_sent     = 0;
  int unknown_sent    = 0;
  int words_checked   = 0;

  mips_subset_control_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .insn_valid (insn_valid),
    .insn_ready (insn_ready),
    .insn       (insn),
    .ctrl_valid (ctrl_valid),
    .ctrl_ready (ctrl_ready),
    .ctrl       (ctrl)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Expected ID/EX control word for one instruction transaction.
  function automatic ctrl_t predict_ctrl(input insn_t item);
    ctrl_t      word;
    logic [5:0] opcode;
    logic [5:0] funct;
    word   = '0;
    opcode = item.instruction[31:26];
    funct  = item.instruction[5:0];
    if (item.stall_req) begin
      word.operand_clear = CLR_ALL;
      word.valid_res     = 1'b1;
    end else if (opcode == OP_RTYPE) begin
      word.valid_res = 1'b1;
      word.reg_dst   = 1'b1;
      word.reg_write = 1'b1;
      case (funct)
        FN_ADD, FN_ADDU: word.alu_op = ALU_ADD;
        FN_SUB, FN_SUBU: begin
          word.alu_op   = ALU_ADD;
          word.b_negate = 1'b1;
        end
        FN_AND: word.alu_op = ALU_AND;
        FN_OR:  word.alu_op = ALU_OR;
        FN_XOR: word.alu_op = ALU_XOR;
        FN_NOR: begin
          word.alu_op  = ALU_OR;
          word.special = SPC_NORBNE;
        end
        FN_SLT: begin
          word.alu_op   = ALU_SLT;
          word.b_negate = 1'b1;
        end
        FN_NOP: begin
          word.alu_op        = ALU_NOP;
          word.operand_clear = CLR_NOP;
        end
        default: word = '0;
      endcase
    end else begin
      word.valid_res = 1'b1;
      case (opcode)
        OP_ADDI, OP_ADDIU: begin
          word.alu_src   = SRC_SIMM;
          word.alu_op    = ALU_ADD;
          word.reg_write = 1'b1;
        end
        OP_SLTI: begin
          word.alu_src   = SRC_SIMM;
          word.alu_op    = ALU_SLT;
          word.b_negate  = 1'b1;
          word.reg_write = 1'b1;
        end
        OP_LW: begin
          word.alu_src    = SRC_SIMM;
          word.alu_op     = ALU_ADD;
          word.mem_read   = 1'b1;
          word.mem_to_reg = 1'b1;
          word.reg_write  = 1'b1;
        end
        OP_SW: begin
          word.alu_src   = SRC_SIMM;
          word.alu_op    = ALU_ADD;
          word.mem_write = 1'b1;
        end
        OP_BEQ, OP_J: word.operand_clear = CLR_REGS;
        OP_BNE: begin
          word.special       = SPC_NORBNE;
          word.operand_clear = CLR_REGS;
        end
        OP_ANDI: begin
          word.alu_src   = SRC_ZIMM;
          word.alu_op    = ALU_AND;
          word.reg_write = 1'b1;
        end
        OP_ORI: begin
          word.alu_src   = SRC_ZIMM;
          word.alu_op    = ALU_OR;
          word.reg_write = 1'b1;
        end
        OP_LUI: begin
          word.alu_src   = SRC_ZIMM;
          word.alu_op    = ALU_XOR;
          word.reg_write = 1'b1;
          word.special   = SPC_LUI;
        end
        default: word = '0;
      endcase
    end
    return word;
  endfunction

  // One of the recognised encodings, chosen by index, over the given filler bits.
  function automatic logic [31:0] known_encoding(input int sel, input logic [31:0] filler);
    logic [31:0] word;
    logic [5:0]  code;
    word = filler;
    case (sel)
      0:  code = FN_NOP;
      1:  code = FN_ADD;
      2:  code = FN_ADDU;
      3:  code = FN_SUB;
      4:  code = FN_SUBU;
      5:  code = FN_AND;
      6:  code = FN_OR;
      7:  code = FN_XOR;
      8:  code = FN_NOR;
      9:  code = FN_SLT;
      10: code = OP_ADDI;
      11: code = OP_ADDIU;
      12: code = OP_SLTI;
      13: code = OP_ANDI;
      14: code = OP_ORI;
      15: code = OP_LUI;
      16: code = OP_LW;
      17: code = OP_SW;
      18: code = OP_BEQ;
      19: code = OP_BNE;
      default: code = OP_J;
    endcase
    if (sel < RTYPE_ENCODINGS) begin
      word[31:26] = OP_RTYPE;
      word[5:0]   = code;
    end else begin
      word[31:26] = code;
    end
    return word;
  endfunction

  // Mostly well-formed instructions, with bubbles, bad functs and raw noise mixed in.
  function automatic insn_t random_item();
    insn_t item;
    int    pick;
    pick = $urandom_range(0, 99);
    item.instruction = $urandom;
    item.stall_req   = 1'b0;
    if (pick < 65) begin
      item.instruction = known_encoding($urandom_range(0, KNOWN_ENCODINGS - 1), $urandom);
    end else if (pick < 75) begin
      item.stall_req = 1'b1;
    end else if (pick < 85) begin
      item.instruction[31:26] = OP_RTYPE;
    end else begin
      item.stall_req = 1'($urandom_range(0, 1));
    end
    return item;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int pick;
    if (no_idle) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offer one instruction transaction and record its prediction once accepted.
  task automatic send_insn(input insn_t item);
    int    gap;
    ctrl_t want;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      insn_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    insn       <= item;
    insn_valid <= 1'b1;
    @(posedge clk);
    while (!insn_ready) @(posedge clk);
    want = predict_ctrl(item);
    pending_ctrl.push_back(want);
    insns_sent++;
    if (item.stall_req) begin
      stalls_sent++;
    end
    if (!want.valid_res) begin
      unknown_sent++;
    end
  endtask

  // Every recognised encoding once; the nop is sent as the all-zero word.
  task automatic test_each_encoding();
    insn_t item;
    for (int sel = 0; sel < KNOWN_ENCODINGS; sel++) begin
      item.instruction = known_encoding(sel, (sel == 0) ? 32'h0 : $urandom);
      item.stall_req   = 1'b0;
      send_insn(item);
    end
  endtask

  // All-ones word, a bubble over a valid load, a bad funct and an unknown opcode.
  task automatic test_corner_words();
    insn_t item;
    item.instruction = 32'hffff_ffff;
    item.stall_req   = 1'b0;
    send_insn(item);
    item.instruction = known_encoding(16, $urandom);
    item.stall_req   = 1'b1;
    send_insn(item);
    item.instruction = {OP_RTYPE, 20'hfffff, 6'd1};
    item.stall_req   = 1'b0;
    send_insn(item);
    item.instruction = {6'h3f, 26'h0};
    item.stall_req   = 1'b0;
    send_insn(item);
  endtask

  task automatic test_random_stream();
    repeat (RANDOM_ITEMS) send_insn(random_item());
  endtask

  // Full rate on both sides, no idle cycles.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (BURST_ITEMS) send_insn(random_item());
    no_idle = 1'b0;
  endtask

  // The sink holds off for a long stretch while instructions keep coming.
  task automatic test_result_backpressure();
    no_idle         = 1'b1;
    hold_off_cycles = HOLD_CYCLES;
    repeat (HOLD_ITEMS) send_insn(random_item());
    no_idle = 1'b0;
  endtask

  // Result sink: random stalls, plus one long hold-off when it is requested.
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    ctrl_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0 && !hold_done) begin
        ctrl_ready <= 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        ctrl_ready <= 1'b0;
        stall_left--;
      end else begin
        ctrl_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Report one field that differs from its prediction.
  function automatic void compare_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted control word with the oldest prediction.
  always @(posedge clk) begin : ctrl_monitor
    ctrl_t want;
    if (!rst && ctrl_valid && ctrl_ready) begin
      if (pending_ctrl.size() == 0) begin
        $error("control word %h arrived with no instruction outstanding", ctrl);
        mismatch_count++;
      end else begin
        want = pending_ctrl.pop_front();
        compare_field("alu_src", 3'(want.alu_src), 3'(ctrl.alu_src));
        compare_field("alu_op", want.alu_op, ctrl.alu_op);
        compare_field("b_negate", 3'(want.b_negate), 3'(ctrl.b_negate));
        compare_field("mem_read", 3'(want.mem_read), 3'(ctrl.mem_read));
        compare_field("mem_write", 3'(want.mem_write), 3'(ctrl.mem_write));
        compare_field("mem_to_reg", 3'(want.mem_to_reg), 3'(ctrl.mem_to_reg));
        compare_field("reg_dst", 3'(want.reg_dst), 3'(ctrl.reg_dst));
        compare_field("reg_write", 3'(want.reg_write), 3'(ctrl.reg_write));
        compare_field("special", 3'(want.special), 3'(ctrl.special));
        compare_field("operand_clear", 3'(want.operand_clear), 3'(ctrl.operand_clear));
        compare_field("valid_res", 3'(want.valid_res), 3'(ctrl.valid_res));
        words_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d control words outstanding",
               cycle_count, pending_ctrl.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst        = 1'b1;
    insn_valid = 1'b0;
    insn       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_each_encoding();
    test_corner_words();
    test_random_stream();
    test_back_to_back();
    test_result_backpressure();

    // Let the last results drain.
    @(negedge clk);
    insn_valid <= 1'b0;
    while (pending_ctrl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Decoded %0d instructions: %0d bubbles, %0d unknown encodings.",
             insns_sent, stalls_sent, unknown_sent);
    $display("Checked %0d control words under random gaps, full rate and a long hold-off.",
             words_checked);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mscd_pkg.sv
rtl/core/mscd_decode.sv
rtl/core/mips_subset_control_decoder.sv
tb/tb.sv
